### hdl/token_scanner_macros.svh
// token_scanner_macros.svh: assertion macros shared by the scanner RTL
// depends on: nothing; each macro expects clk and rst_n in the including scope
`ifndef TOKEN_SCANNER_MACROS_SVH
`define TOKEN_SCANNER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define TS_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("token_scanner assertion failed");
// next-cycle implication, checked out of reset
`define TS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("token_scanner assertion failed");
`else
`define TS_ASSERT(lbl, ante, cons)
`define TS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hdl/tscan_pkg.sv
// tscan_pkg: token types, kind codes, character classes and keyword table
// depends on: nothing
package tscan_pkg;

    // longest word prefix kept for keyword matching
    localparam int KW_CHARS   = 5;
    localparam int KW_MAXLEN  = 5;
    localparam int KW_NUM     = 14;

    // record queue between front and back
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = QPTR_W + 1;

    // token kind codes
    localparam logic [4:0] K_END     = 5'd0;
    localparam logic [4:0] K_LT      = 5'd1;
    localparam logic [4:0] K_GT      = 5'd2;
    localparam logic [4:0] K_SHR     = 5'd3;
    localparam logic [4:0] K_PLUS    = 5'd4;
    localparam logic [4:0] K_MINUS   = 5'd5;
    localparam logic [4:0] K_MULT    = 5'd6;
    localparam logic [4:0] K_EXP     = 5'd7;
    localparam logic [4:0] K_NOT     = 5'd8;
    localparam logic [4:0] K_NE      = 5'd9;
    localparam logic [4:0] K_MOD     = 5'd10;
    localparam logic [4:0] K_DIV     = 5'd11;
    localparam logic [4:0] K_LBRACE  = 5'd12;
    localparam logic [4:0] K_RBRACE  = 5'd13;
    localparam logic [4:0] K_ASSIGN  = 5'd14;
    localparam logic [4:0] K_EQ      = 5'd15;
    localparam logic [4:0] K_LABEL   = 5'd16;
    localparam logic [4:0] K_INT     = 5'd17;
    localparam logic [4:0] K_REAL    = 5'd18;
    localparam logic [4:0] K_IDENT   = 5'd19;
    localparam logic [4:0] K_PRINT   = 5'd20;
    localparam logic [4:0] K_INPUT   = 5'd21;
    localparam logic [4:0] K_GOTO    = 5'd22;
    localparam logic [4:0] K_IF      = 5'd23;
    localparam logic [4:0] K_THEN    = 5'd24;
    localparam logic [4:0] K_WHILE   = 5'd25;
    localparam logic [4:0] K_DO      = 5'd26;
    localparam logic [4:0] K_BREAK   = 5'd27;
    localparam logic [4:0] K_KWINT   = 5'd28;
    localparam logic [4:0] K_KWREAL  = 5'd29;
    localparam logic [4:0] K_KWBOOL  = 5'd30;
    localparam logic [4:0] K_INVALID = 5'd31;

    // boolean literal flags
    localparam logic [1:0] BOOL_NONE = 2'd0;
    localparam logic [1:0] BOOL_ZERO = 2'd1;
    localparam logic [1:0] BOOL_ONE  = 2'd2;

    typedef struct packed {
        logic [4:0]  kind;
        logic [23:0] line;
        logic [31:0] start;
        logic [15:0] len;
        logic [1:0]  flag;
        logic        last;
    } tscan_tok_t;

    // all tokens caused by one input beat
    typedef struct packed {
        tscan_tok_t tok0;
        tscan_tok_t tok1;
        logic       two;
    } tscan_rec_t;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } tscan_qstat_t;

    typedef struct packed {
        logic       hit;
        logic [4:0] kind;
        logic [1:0] flag;
    } tscan_kw_t;

    // keyword text, first character in the top byte, zero padded
    localparam logic [39:0] KW_TEXT [KW_NUM] = '{
        "input", {"moo", 16'h0}, "print", {"goto", 8'h0}, {"if", 24'h0},
        {"then", 8'h0}, "while", {"do", 24'h0}, {"true", 8'h0}, "false",
        "break", {"int", 16'h0}, {"real", 8'h0}, {"bool", 8'h0}
    };
    localparam logic [2:0] KW_LEN [KW_NUM] = '{
        3'd5, 3'd3, 3'd5, 3'd4, 3'd2, 3'd4, 3'd5, 3'd2, 3'd4, 3'd5, 3'd5, 3'd3,
        3'd4, 3'd4
    };
    localparam logic [4:0] KW_KIND [KW_NUM] = '{
        K_INPUT, K_PRINT, K_PRINT, K_GOTO, K_IF, K_THEN, K_WHILE, K_DO, K_INT,
        K_INT, K_BREAK, K_KWINT, K_KWREAL, K_KWBOOL
    };
    localparam logic [1:0] KW_FLAG [KW_NUM] = '{
        BOOL_NONE, BOOL_NONE, BOOL_NONE, BOOL_NONE, BOOL_NONE, BOOL_NONE,
        BOOL_NONE, BOOL_NONE, BOOL_ONE, BOOL_ZERO, BOOL_NONE, BOOL_NONE,
        BOOL_NONE, BOOL_NONE
    };

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_name(input logic [7:0] c);
        return is_digit(c) || is_alpha(c) || (c == "_");
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    // parallel match of the stored word prefix against every keyword
    function automatic tscan_kw_t kw_match(input logic [KW_CHARS-1:0][7:0] chars,
                                           input logic [15:0] count);
        tscan_kw_t res;
        logic      eq;
        res = '0;
        for (int i = 0; i < KW_NUM; i++) begin
            eq = (count == 16'(KW_LEN[i]));
            for (int j = 0; j < KW_MAXLEN; j++) begin
                eq = eq && (chars[j] == KW_TEXT[i][39 - 8*j -: 8]);
            end
            if (eq && !res.hit) begin
                res.hit  = 1'b1;
                res.kind = KW_KIND[i];
                res.flag = KW_FLAG[i];
            end
        end
        return res;
    endfunction

    function automatic tscan_tok_t mk_tok(input logic [4:0] kind, input logic [23:0] line,
                                          input logic [31:0] start,
                                          input logic [15:0] len, input logic [1:0] flag);
        tscan_tok_t t;
        t.kind  = kind;
        t.line  = line;
        t.start = start;
        t.len   = len;
        t.flag  = flag;
        t.last  = 1'b0;
        return t;
    endfunction

endpackage

### hdl/token_scanner.sv
// token_scanner: top level of the streaming lexer
// depends on: tscan_pkg, tscan_front, tscan_queue, tscan_back
//
// The scanner takes one source byte per cycle on the src channel and a final beat with
// end_of_text set; the front updates the lexer state for each byte and writes the zero,
// one or two tokens that byte closes as one record into a four-entry queue. The back
// sends one token per cycle from a registered output while tok_ready is high; the
// queue absorbs the bursts of bytes that close two tokens, and src_ready drops only
// while it is full. An accepted byte's first token passes the queue storage and then the
// output register. After the end token the block ignores every further beat until reset.

module token_scanner (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        src_valid,
    output logic        src_ready,
    input  logic [7:0]  char_code,
    input  logic        end_of_text,
    output logic        tok_valid,
    input  logic        tok_ready,
    output logic [4:0]  token_kind,
    output logic [23:0] line_no,
    output logic [31:0] start_offset,
    output logic [15:0] token_length,
    output logic [1:0]  bool_literal,
    output logic        last_of_run
);
    import tscan_pkg::*;

    logic          push;
    logic          pop;
    tscan_rec_t    push_rec;
    tscan_rec_t    head_rec;
    tscan_qstat_t  qstat;
    tscan_tok_t    tok;

    // byte intake and classification
    tscan_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .src_valid   (src_valid),
        .src_ready   (src_ready),
        .char_code   (char_code),
        .end_of_text (end_of_text),
        .qstat       (qstat),
        .push        (push),
        .push_rec    (push_rec)
    );

    // record queue
    tscan_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .qstat    (qstat)
    );

    // token output
    tscan_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_rec  (head_rec),
        .qstat     (qstat),
        .pop       (pop),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok       (tok)
    );

    assign token_kind   = tok.kind;
    assign line_no      = tok.line;
    assign start_offset = tok.start;
    assign token_length = tok.len;
    assign bool_literal = tok.flag;
    assign last_of_run  = tok.last;

endmodule

### hdl/tscan_front.sv
// tscan_front: accepts source bytes, tracks the scanner state, builds token records
// depends on: tscan_pkg, token_scanner_macros.svh
`include "token_scanner_macros.svh"

module tscan_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   src_valid,
    output logic                   src_ready,
    input  logic [7:0]             char_code,
    input  logic                   end_of_text,
    input  tscan_pkg::tscan_qstat_t qstat,
    output logic                   push,
    output tscan_pkg::tscan_rec_t  push_rec
);
    import tscan_pkg::*;

    // scanner modes
    localparam logic [2:0] M_IDLE   = 3'd0;
    localparam logic [2:0] M_GT     = 3'd1;
    localparam logic [2:0] M_STAR   = 3'd2;
    localparam logic [2:0] M_BANG   = 3'd3;
    localparam logic [2:0] M_EQ     = 3'd4;
    localparam logic [2:0] M_LABEL  = 3'd5;
    localparam logic [2:0] M_NUMBER = 3'd6;
    localparam logic [2:0] M_WORD   = 3'd7;

    logic [2:0]                mode_reg, mode_next;
    logic                      dot_reg, dot_next;
    logic [KW_CHARS-1:0][7:0]  chars_reg, chars_next;
    logic                      long_reg, long_next;
    logic [31:0]               tstart_reg, tstart_next;
    logic [15:0]               tcount_reg, tcount_next;
    logic [23:0]               line_reg, line_next;
    logic [31:0]               pos_reg, pos_next;
    logic                      done_reg, done_next;

    logic                      accept;
    logic                      flush_v;
    tscan_tok_t                flush_tok;
    tscan_kw_t                 kw;
    logic                      a_v, b_v;
    tscan_tok_t                a_tok, b_tok;
    logic [15:0]               count_inc;

    assign src_ready = !qstat.full;
    assign accept    = src_valid && src_ready;
    assign count_inc = (tcount_reg != 16'hFFFF) ? tcount_reg + 16'd1 : tcount_reg;
    assign kw        = kw_match(chars_reg, tcount_reg);

    // pending token of the current mode
    always_comb
    begin
        flush_v   = 1'b1;
        flush_tok = mk_tok(K_END, line_reg, tstart_reg, 16'd0, BOOL_NONE);
        unique case (mode_reg)
            M_IDLE:   flush_v = 1'b0;
            M_GT:     flush_tok.kind = K_GT;
            M_STAR:   flush_tok.kind = K_MULT;
            M_BANG:   flush_tok.kind = K_NOT;
            M_EQ:     flush_tok.kind = K_ASSIGN;
            M_LABEL:
            begin
                flush_tok.kind = K_LABEL;
                flush_tok.len  = tcount_reg;
            end
            M_NUMBER:
            begin
                flush_tok.kind = dot_reg ? K_REAL : K_INT;
                flush_tok.len  = tcount_reg;
            end
            M_WORD:
            begin
                if (kw.hit && !long_reg) begin
                    flush_tok.kind = kw.kind;
                    flush_tok.flag = kw.flag;
                    flush_tok.len  = (kw.flag != BOOL_NONE) ? 16'd1 : 16'd0;
                end else begin
                    flush_tok.kind = K_IDENT;
                    flush_tok.len  = tcount_reg;
                end
            end
            default:  flush_v = 1'b0;
        endcase
    end

    // next scanner state and the tokens this beat causes
    always_comb
    begin
        mode_next   = mode_reg;
        dot_next    = dot_reg;
        chars_next  = chars_reg;
        long_next   = long_reg;
        tstart_next = tstart_reg;
        tcount_next = tcount_reg;
        line_next   = line_reg;
        pos_next    = pos_reg;
        done_next   = done_reg;
        a_v         = 1'b0;
        a_tok       = flush_tok;
        b_v         = 1'b0;
        b_tok       = mk_tok(K_END, line_reg, pos_reg, 16'd0, BOOL_NONE);

        if (!done_reg) begin
            if (end_of_text) begin
                a_v       = flush_v;
                b_v       = 1'b1;
                mode_next = M_IDLE;
                done_next = 1'b1;
            end else begin
                pos_next = (pos_reg != 32'hFFFF_FFFF) ? pos_reg + 32'd1 : pos_reg;
                if ((mode_reg == M_LABEL) && is_name(char_code)) begin
                    tcount_next = count_inc;
                end else if ((mode_reg == M_NUMBER) &&
                             (is_digit(char_code) || ((char_code == ".") && !dot_reg))) begin
                    if (char_code == ".") begin
                        dot_next = 1'b1;
                    end
                    tcount_next = count_inc;
                end else if ((mode_reg == M_WORD) && is_name(char_code)) begin
                    for (int j = 0; j < KW_CHARS; j++) begin
                        if (tcount_reg == 16'(j)) begin
                            chars_next[j] = char_code;
                        end
                    end
                    if (tcount_reg >= 16'(KW_CHARS)) begin
                        long_next = 1'b1;
                    end
                    tcount_next = count_inc;
                end else if ((mode_reg == M_GT) && (char_code == ">")) begin
                    b_v       = 1'b1;
                    b_tok     = mk_tok(K_SHR, line_reg, tstart_reg, 16'd0, BOOL_NONE);
                    mode_next = M_IDLE;
                end else if ((mode_reg == M_STAR) && (char_code == "*")) begin
                    b_v       = 1'b1;
                    b_tok     = mk_tok(K_EXP, line_reg, tstart_reg, 16'd0, BOOL_NONE);
                    mode_next = M_IDLE;
                end else if ((mode_reg == M_BANG) && (char_code == "=")) begin
                    b_v       = 1'b1;
                    b_tok     = mk_tok(K_NE, line_reg, tstart_reg, 16'd0, BOOL_NONE);
                    mode_next = M_IDLE;
                end else if ((mode_reg == M_EQ) && (char_code == "=")) begin
                    b_v       = 1'b1;
                    b_tok     = mk_tok(K_EQ, line_reg, tstart_reg, 16'd0, BOOL_NONE);
                    mode_next = M_IDLE;
                end else begin
                    // close the pending token; this byte may start a new one
                    a_v         = flush_v;
                    mode_next   = M_IDLE;
                    tstart_next = pos_reg;
                    tcount_next = 16'd0;
                    b_tok       = mk_tok(K_END, line_reg, pos_reg, 16'd0, BOOL_NONE);
                    unique case (char_code)
                        "<":
                        begin
                            b_v        = 1'b1;
                            b_tok.kind = K_LT;
                        end
                        "+":
                        begin
                            b_v        = 1'b1;
                            b_tok.kind = K_PLUS;
                        end
                        "-":
                        begin
                            b_v        = 1'b1;
                            b_tok.kind = K_MINUS;
                        end
                        "%":
                        begin
                            b_v        = 1'b1;
                            b_tok.kind = K_MOD;
                        end
                        "/":
                        begin
                            b_v        = 1'b1;
                            b_tok.kind = K_DIV;
                        end
                        "{":
                        begin
                            b_v        = 1'b1;
                            b_tok.kind = K_LBRACE;
                        end
                        "}":
                        begin
                            b_v        = 1'b1;
                            b_tok.kind = K_RBRACE;
                        end
                        ">": mode_next = M_GT;
                        "*": mode_next = M_STAR;
                        "!": mode_next = M_BANG;
                        "=": mode_next = M_EQ;
                        ":":
                        begin
                            tstart_next = (pos_reg != 32'hFFFF_FFFF) ?
                                          pos_reg + 32'd1 : pos_reg;
                            mode_next   = M_LABEL;
                        end
                        default:
                        begin
                            if (is_space(char_code)) begin
                                if ((char_code == 8'h0A) && (line_reg != 24'hFF_FFFF)) begin
                                    line_next = line_reg + 24'd1;
                                end
                            end else if (is_digit(char_code) || (char_code == ".")) begin
                                mode_next   = M_NUMBER;
                                dot_next    = (char_code == ".");
                                tcount_next = 16'd1;
                            end else if (is_alpha(char_code)) begin
                                mode_next     = M_WORD;
                                chars_next    = '0;
                                chars_next[0] = char_code;
                                long_next     = 1'b0;
                                tcount_next   = 16'd1;
                            end else begin
                                b_v        = 1'b1;
                                b_tok.kind = K_INVALID;
                                b_tok.len  = 16'd1;
                            end
                        end
                    endcase
                end
            end
        end
    end

    // pack the tokens of this beat into one record
    always_comb
    begin
        push_rec.tok0      = a_v ? a_tok : b_tok;
        push_rec.tok0.last = !(a_v && b_v);
        push_rec.tok1      = b_tok;
        push_rec.tok1.last = 1'b1;
        push_rec.two       = a_v && b_v;
        push               = accept && (a_v || b_v);
    end

    // scanner state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg   <= M_IDLE;
            dot_reg    <= 1'b0;
            chars_reg  <= '0;
            long_reg   <= 1'b0;
            tstart_reg <= '0;
            tcount_reg <= '0;
            line_reg   <= 24'd1;
            pos_reg    <= '0;
            done_reg   <= 1'b0;
        end else if (accept) begin
            mode_reg   <= mode_next;
            dot_reg    <= dot_next;
            chars_reg  <= chars_next;
            long_reg   <= long_next;
            tstart_reg <= tstart_next;
            tcount_reg <= tcount_next;
            line_reg   <= line_next;
            pos_reg    <= pos_next;
            done_reg   <= done_next;
        end
    end

    `TS_ASSERT_NEXT(a_done_sticky, done_reg, done_reg)
    `TS_ASSERT(a_line_nonzero, 1'b1, line_reg != 24'd0)
    `TS_ASSERT(a_push_room, push, !qstat.full)

endmodule

### hdl/tscan_queue.sv
// tscan_queue: short record queue decoupling the scanner front from the token back
// depends on: tscan_pkg, token_scanner_macros.svh
`include "token_scanner_macros.svh"

module tscan_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  tscan_pkg::tscan_rec_t   push_rec,
    input  logic                    pop,
    output tscan_pkg::tscan_rec_t   head_rec,
    output tscan_pkg::tscan_qstat_t qstat
);
    import tscan_pkg::*;

    tscan_rec_t          store_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_reg, wr_next;
    logic [QPTR_W-1:0]   rd_reg, rd_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;

    assign qstat.full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign qstat.empty = (cnt_reg == '0);
    assign head_rec    = store_reg[rd_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // record storage
    always_ff @(posedge clk)
    begin
        if (push) begin
            store_reg[wr_reg] <= push_rec;
        end
    end

    `TS_ASSERT(a_q_no_underflow, pop, !qstat.empty)
    `TS_ASSERT(a_q_count_range, 1'b1, cnt_reg <= QCNT_W'(QDEPTH))

endmodule

### hdl/tscan_back.sv
// tscan_back: drains token records, one token per beat, through an output register
// depends on: tscan_pkg, token_scanner_macros.svh
`include "token_scanner_macros.svh"

module tscan_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  tscan_pkg::tscan_rec_t   head_rec,
    input  tscan_pkg::tscan_qstat_t qstat,
    output logic                    pop,
    output logic                    tok_valid,
    input  logic                    tok_ready,
    output tscan_pkg::tscan_tok_t   tok
);
    import tscan_pkg::*;

    logic        valid_reg, valid_next;
    logic        phase_reg, phase_next;
    tscan_tok_t  out_reg;
    logic        load;

    // load a token when the output slot is free or being taken
    assign load       = (!valid_reg || tok_ready) && !qstat.empty;
    assign pop        = load && (phase_reg || !head_rec.two);
    assign valid_next = load || (valid_reg && !tok_ready);
    assign phase_next = load ? (!phase_reg && head_rec.two) : phase_reg;
    assign tok_valid  = valid_reg;
    assign tok        = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (load) begin
            out_reg <= phase_reg ? head_rec.tok1 : head_rec.tok0;
        end
    end

    `TS_ASSERT(a_phase_two, phase_reg, !qstat.empty && head_rec.two)
    `TS_ASSERT_NEXT(a_second_half, load && !phase_reg && head_rec.two, phase_reg)

endmodule
